@@ rtl/core/pgk_pkg.sv @@
// Shared types and constants for the pairwise gravity kick block.
// Holds the queue word layout, the back-end state encoding and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pgk_pkg;

  localparam int FRACTION_BITS_DEF = 24;
  localparam int WORD_W = 32;
  localparam int DM_W   = 33;

  localparam logic CFG_SOFTENING = 1'b0;
  localparam logic CFG_STEP      = 1'b1;

  typedef struct packed {
    logic [2:0][DM_W-1:0]   dm;
    logic [2:0]             dneg;
    logic [2:0]             dpos;
    logic [WORD_W-1:0]      mass;
    logic [2:0][WORD_W-1:0] vel;
    logic                   last;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_SQ,
    B_ROOT,
    B_CUBE_LO,
    B_CUBE_HI,
    B_NUM,
    B_DIV,
    B_ACC,
    B_KICK_LO,
    B_KICK_HI,
    B_KICK_FIN,
    B_OUT
  } bstate_t;

endpackage
`default_nettype wire

@@ rtl/core/pgk_front.sv @@
// Front end: accepts pair words, forms per-axis separation magnitude and sign.
// Depends on pgk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgk_front (
  input  wire logic [319:0]   in_tdata,
  input  wire logic           in_tlast,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic           q_full,
  output logic                push,
  output pgk_pkg::item_t      item
);

  logic signed [32:0] dx [3];

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dx[k] = $signed({in_tdata[32*k+31], in_tdata[32*k +: 32]})
            - $signed({in_tdata[32*(k+6)+31], in_tdata[32*(k+6) +: 32]});
      item.dm[k]   = dx[k][32] ? 33'(-dx[k]) : 33'(dx[k]);
      item.dneg[k] = dx[k][32];
      item.dpos[k] = !dx[k][32] && (dx[k] != 33'sd0);
      item.vel[k]  = in_tdata[32*(k+3) +: 32];
    end
    item.mass = in_tdata[319:288];
    item.last = in_tlast;
  end

endmodule
`default_nettype wire

@@ rtl/core/pgk_queue.sv @@
// Two-entry queue between front and back end.
// Depends on pgk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgk_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire pgk_pkg::item_t wr_item,
  output logic                full,
  input  wire logic           pop,
  output logic                not_empty,
  output pgk_pkg::item_t      rd_item
);

  pgk_pkg::item_t mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign not_empty = (cnt_r != 2'd0);
  assign rd_item   = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wr_item;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/pgk_back.sv @@
// Back end: distance, integer root, cube, per-axis divide, saturating
// accumulation and the velocity kick, sequenced over shared units.
// Depends on pgk_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pgk_back #(
  parameter int FRACTION_BITS = pgk_pkg::FRACTION_BITS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [31:0]    softening_sq,
  input  wire logic [31:0]    step_length,
  input  wire logic           q_valid,
  input  wire pgk_pkg::item_t q_item,
  output logic                pop,
  output logic [95:0]         out_tdata,
  output logic                out_tvalid,
  input  wire logic           out_tready
);

  localparam int S_W   = 66;
  localparam int Q_W   = 34;
  localparam int C_W   = 100;
  localparam int NUM_W = 65 + 2 * FRACTION_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  pgk_pkg::bstate_t state_r, state_nxt;
  pgk_pkg::item_t   cur_r, cur_nxt;
  logic [1:0]       ax_r, ax_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [S_W-1:0]   s_r, s_nxt;
  logic [Q_W-1:0]   q_r, q_nxt;
  logic [C_W-1:0]   c_r, c_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [C_W-1:0]   rem_r, rem_nxt;
  logic [63:0]      quo_r, quo_nxt;
  logic             ovf_r, ovf_nxt;
  logic [2:0][63:0] acc_r, acc_nxt;
  logic [63:0]      plo_r, plo_nxt, phi_r, phi_nxt;
  logic [2:0][31:0] res_r, res_nxt;
  logic [95:0]      out_r, out_nxt;
  logic             ov_r, ov_nxt;

  logic [S_W-1:0]     sq_sum;
  logic [Q_W-1:0]     cand;
  logic [67:0]        cand_sq;
  logic [C_W:0]       rem_sh;
  logic               ge;
  logic [63:0]        tq;
  logic signed [64:0] term, asum;
  logic [63:0]        amag;
  logic [31:0]        smag;
  logic [95:0]        prod, pfull;
  logic [33:0]        pm;
  logic               kneg;
  logic signed [35:0] vsum;

  assign out_tdata  = out_r;
  assign out_tvalid = ov_r;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    ax_nxt    = ax_r;
    cnt_nxt   = cnt_r;
    s_nxt     = s_r;
    q_nxt     = q_r;
    c_nxt     = c_r;
    num_nxt   = num_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    ovf_nxt   = ovf_r;
    acc_nxt   = acc_r;
    plo_nxt   = plo_r;
    phi_nxt   = phi_r;
    res_nxt   = res_r;
    out_nxt   = out_r;
    ov_nxt    = ov_r && !out_tready;
    pop       = 1'b0;

    sq_sum  = s_r + S_W'(cur_r.dm[ax_r] * cur_r.dm[ax_r]);
    cand    = q_r | (Q_W'(1) << cnt_r[5:0]);
    cand_sq = cand * cand;
    rem_sh  = {rem_r, num_r[NUM_W-1]};
    ge      = rem_sh >= {1'b0, c_r};
    tq      = (ovf_r || quo_r[63]) ? 64'h7FFF_FFFF_FFFF_FFFF : quo_r;
    term    = cur_r.dpos[ax_r] ? -$signed({1'b0, tq})
            : (cur_r.dneg[ax_r] ? $signed({1'b0, tq}) : 65'sd0);
    asum    = $signed({acc_r[ax_r][63], acc_r[ax_r]}) + term;
    amag    = acc_r[ax_r][63] ? 64'(-acc_r[ax_r]) : acc_r[ax_r];
    smag    = step_length[31] ? 32'(-step_length) : step_length;
    kneg    = acc_r[ax_r][63] ^ step_length[31];
    prod    = {32'd0, plo_r} + {phi_r, 32'd0};
    pfull   = prod >> FRACTION_BITS;
    pm      = (pfull > 96'h2_0000_0000) ? 34'h2_0000_0000 : pfull[33:0];
    vsum    = kneg ? $signed({{4{cur_r.vel[ax_r][31]}}, cur_r.vel[ax_r]}) - $signed({2'b0, pm})
                   : $signed({{4{cur_r.vel[ax_r][31]}}, cur_r.vel[ax_r]}) + $signed({2'b0, pm});

    case (state_r)
      pgk_pkg::B_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          cur_nxt   = q_item;
          s_nxt     = S_W'({softening_sq, FRACTION_BITS'(0)});
          ax_nxt    = 2'd0;
          state_nxt = pgk_pkg::B_SQ;
        end
      end
      pgk_pkg::B_SQ: begin
        s_nxt = sq_sum;
        if (ax_r == 2'd2) begin
          ax_nxt  = 2'd0;
          q_nxt   = '0;
          cnt_nxt = CNT_W'(Q_W - 1);
          if (sq_sum == '0) begin
            state_nxt = cur_r.last ? pgk_pkg::B_KICK_LO : pgk_pkg::B_IDLE;
          end else begin
            state_nxt = pgk_pkg::B_ROOT;
          end
        end else begin
          ax_nxt = ax_r + 2'd1;
        end
      end
      pgk_pkg::B_ROOT: begin
        if ({2'b0, s_r} >= cand_sq) begin
          q_nxt = cand;
        end
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = pgk_pkg::B_CUBE_LO;
        end
      end
      pgk_pkg::B_CUBE_LO: begin
        c_nxt     = C_W'(s_r[32:0] * q_r);
        state_nxt = pgk_pkg::B_CUBE_HI;
      end
      pgk_pkg::B_CUBE_HI: begin
        c_nxt     = c_r + {67'(s_r[65:33] * q_r), 33'd0};
        ax_nxt    = 2'd0;
        state_nxt = pgk_pkg::B_NUM;
      end
      pgk_pkg::B_NUM: begin
        num_nxt   = {65'(cur_r.dm[ax_r] * cur_r.mass), (2 * FRACTION_BITS)'(0)};
        rem_nxt   = '0;
        quo_nxt   = '0;
        ovf_nxt   = 1'b0;
        cnt_nxt   = CNT_W'(NUM_W - 1);
        state_nxt = pgk_pkg::B_DIV;
      end
      pgk_pkg::B_DIV: begin
        rem_nxt = ge ? C_W'(rem_sh - {1'b0, c_r}) : C_W'(rem_sh);
        quo_nxt = {quo_r[62:0], ge};
        ovf_nxt = ovf_r || quo_r[63];
        num_nxt = num_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = pgk_pkg::B_ACC;
        end
      end
      pgk_pkg::B_ACC: begin
        case (asum[64:63])
          2'b01:   acc_nxt[ax_r] = 64'h7FFF_FFFF_FFFF_FFFF;
          2'b10:   acc_nxt[ax_r] = 64'h8000_0000_0000_0000;
          default: acc_nxt[ax_r] = asum[63:0];
        endcase
        if (ax_r == 2'd2) begin
          ax_nxt    = 2'd0;
          state_nxt = cur_r.last ? pgk_pkg::B_KICK_LO : pgk_pkg::B_IDLE;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = pgk_pkg::B_NUM;
        end
      end
      pgk_pkg::B_KICK_LO: begin
        plo_nxt   = amag[31:0] * smag;
        state_nxt = pgk_pkg::B_KICK_HI;
      end
      pgk_pkg::B_KICK_HI: begin
        phi_nxt   = amag[63:32] * smag;
        state_nxt = pgk_pkg::B_KICK_FIN;
      end
      pgk_pkg::B_KICK_FIN: begin
        if (vsum > 36'sh0_7FFF_FFFF) begin
          res_nxt[ax_r] = 32'h7FFF_FFFF;
        end else if (vsum < -36'sh0_8000_0000) begin
          res_nxt[ax_r] = 32'h8000_0000;
        end else begin
          res_nxt[ax_r] = vsum[31:0];
        end
        if (ax_r == 2'd2) begin
          state_nxt = pgk_pkg::B_OUT;
        end else begin
          ax_nxt    = ax_r + 2'd1;
          state_nxt = pgk_pkg::B_KICK_LO;
        end
      end
      pgk_pkg::B_OUT: begin
        if (!ov_r || out_tready) begin
          out_nxt   = {res_r[2], res_r[1], res_r[0]};
          ov_nxt    = 1'b1;
          acc_nxt   = '0;
          ax_nxt    = 2'd0;
          state_nxt = pgk_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = pgk_pkg::B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pgk_pkg::B_IDLE;
      ax_r    <= 2'd0;
      acc_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ax_r    <= ax_nxt;
      acc_r   <= acc_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    cnt_r <= cnt_nxt;
    s_r   <= s_nxt;
    q_r   <= q_nxt;
    c_r   <= c_nxt;
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    ovf_r <= ovf_nxt;
    plo_r <= plo_nxt;
    phi_r <= phi_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/core/pairwise_gravity_kick.sv @@
// Softened direct-summation gravity kick top: config registers, front, queue, back end.
// Depends on pgk_pkg and the submodules.
// Each pair holds the back end through square-sum, root, cube and one NUM_W-bit divide per axis,
// NUM_W = 65 + 2*FRACTION_BITS, or only the square-sum on zero distance; a last word adds the kick,
// plus any output register wait. A new pair word is taken only from idle; two more wait in the queue.
// Synchronous active-low reset clears control state, accumulators and config registers.
`timescale 1ns / 1ps
`default_nettype none
module pairwise_gravity_kick #(
  parameter int FRACTION_BITS = pgk_pkg::FRACTION_BITS_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [31:0]  cfg_wdata,
  // target_x, target_y, target_z, target_vx, target_vy, target_vz,
  // source_x, source_y, source_z, source_mass
  input  wire logic [319:0] in_tdata,
  input  wire logic         in_tlast,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // new_vx, new_vy, new_vz
  output logic [95:0]       out_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready
);

  logic [31:0] soft_r, soft_nxt, step_r, step_nxt;
  logic           q_full, push, pop, q_valid;
  pgk_pkg::item_t f_item, q_item;

  always_comb begin
    soft_nxt = soft_r;
    step_nxt = step_r;
    if (cfg_we) begin
      case (cfg_index)
        pgk_pkg::CFG_SOFTENING: soft_nxt = cfg_wdata;
        pgk_pkg::CFG_STEP:      step_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      soft_r <= '0;
      step_r <= '0;
    end else begin
      soft_r <= soft_nxt;
      step_r <= step_nxt;
    end
  end

  pgk_front u_front (
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .q_full    (q_full),
    .push      (push),
    .item      (f_item)
  );

  pgk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .wr_item   (f_item),
    .full      (q_full),
    .pop       (pop),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  pgk_back #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .softening_sq (soft_r),
    .step_length  (step_r),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .pop          (pop),
    .out_tdata    (out_tdata),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready)
  );

endmodule
`default_nettype wire
